/* hw/rtl/pmq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pmq_pkg;

  // Default sizing of the shared store and the queue table
  localparam int MAX_SLOTS_DEF  = 128;
  localparam int MAX_QUEUES_DEF = 16;

  // Field and register widths
  localparam int WORD_W     = 32;
  localparam int SLOTS_W    = 8;
  localparam int QCNT_W     = 5;
  localparam int QNUM_W     = 5;
  localparam int CMD_W      = 2;
  localparam int CFG_DATA_W = 8;
  localparam int PTR_W      = 8;

  // Segment size divider: one quotient bit per cycle
  localparam int DIV_STEPS = SLOTS_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam int RESET_TOTAL_SLOTS = 16;
  localparam int RESET_QUEUE_COUNT = 4;

  // Commands; any other code is a status query
  localparam logic [CMD_W-1:0] CMD_ENQ = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ = 2'd1;

  // Configuration register indexes
  localparam logic CFG_TOTAL_SLOTS = 1'b0;
  localparam logic CFG_QUEUE_COUNT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_BAD_QUEUE = 2'd3
  } status_t;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [QNUM_W-1:0]        queue_number;
    logic signed [WORD_W-1:0] value;
  } req_t;

  typedef struct packed {
    status_t                  status;
    logic signed [WORD_W-1:0] data_out;
    logic                     empty_flag;
    logic                     full_flag;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic update;
    logic emit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic busy;
    logic rsp_free;
  } dp_status_t;

  function automatic logic [SLOTS_W-1:0] clamp_slots(logic [SLOTS_W-1:0] v, int max_slots);
    logic [SLOTS_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SLOTS_W'(1);
    end else if (int'(v) > max_slots) begin
      r = SLOTS_W'(max_slots);
    end
    return r;
  endfunction

  function automatic logic [QCNT_W-1:0] clamp_queues(logic [QCNT_W-1:0] v, int max_queues);
    logic [QCNT_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = QCNT_W'(1);
    end else if (int'(v) > max_queues) begin
      r = QCNT_W'(max_queues);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/partitioned_multi_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid/req_stall  | req_t: cmd, queue_number, value
// rsp     | out       | rsp_valid/rsp_stall  | rsp_t: status, data_out, empty_flag, full_flag
// cfg     | in        | cfg_we               | cfg_index, cfg_data (no read-back)
//
// Each word steps through accept, pointer read, pointer update with store
// access and hand-off to the output register; the pointer read step covers the pointer RAM read latency.
// After reset and after every register write, the segment size divider runs
// with req_stall high.
// A waiting result sits in the output register while the next word is taken;
// a second result waits in HANDOFF until rsp_stall drops.
module partitioned_multi_queue #(
  parameter int MAX_SLOTS  = pmq_pkg::MAX_SLOTS_DEF,
  parameter int MAX_QUEUES = pmq_pkg::MAX_QUEUES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           req_valid,
  output logic                                req_stall,
  input  wire pmq_pkg::req_t                  req,
  output logic                                rsp_valid,
  input  wire logic                           rsp_stall,
  output pmq_pkg::rsp_t                       rsp,
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_index,
  input  wire logic [pmq_pkg::CFG_DATA_W-1:0] cfg_data
);

  pmq_pkg::ctrl_cmd_t  cmd;
  pmq_pkg::dp_status_t status;

  // Sequencer: accept, look up pointers, update, hand off
  pmq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cfg_we    (cfg_we),
    .status    (status),
    .cmd       (cmd)
  );

  // Registers, divider, pointer table, shared slot store and output register
  pmq_dp #(
    .MAX_SLOTS  (MAX_SLOTS),
    .MAX_QUEUES (MAX_QUEUES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

`default_nettype wire

/* hw/rtl/pmq_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module pmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                                        clk,
  input  wire logic                                        wen,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic                                        ren,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/pmq_div.sv */
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider: segment size = slots / queues, one quotient bit a cycle
module pmq_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [pmq_pkg::SLOTS_W-1:0] dividend,
  input  wire logic [pmq_pkg::QCNT_W-1:0]  divisor,
  output logic                             busy,
  output logic      [pmq_pkg::SLOTS_W-1:0] quotient
);

  logic [pmq_pkg::DIV_CNT_W-1:0] count;
  logic [pmq_pkg::SLOTS_W-1:0]   num;
  logic [pmq_pkg::QCNT_W-1:0]    rem;
  logic [pmq_pkg::QCNT_W:0]      trial;
  logic                          ge;

  assign trial = {rem, num[pmq_pkg::SLOTS_W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign busy  = count != '0;
  assign quotient = num;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= pmq_pkg::DIV_CNT_W'(pmq_pkg::DIV_STEPS);
    end else if (busy) begin
      count <= count - 1'b1;
    end
  end

  // Shift dividend bits out of the top, quotient bits in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      rem <= '0;
    end else if (busy) begin
      num <= {num[pmq_pkg::SLOTS_W-2:0], ge};
      rem <= ge ? pmq_pkg::QCNT_W'(trial - {1'b0, divisor}) : trial[pmq_pkg::QCNT_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/pmq_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module pmq_dp #(
  parameter int MAX_SLOTS  = pmq_pkg::MAX_SLOTS_DEF,
  parameter int MAX_QUEUES = pmq_pkg::MAX_QUEUES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire pmq_pkg::req_t                  req,
  input  wire logic                           rsp_stall,
  output logic                                rsp_valid,
  output pmq_pkg::rsp_t                       rsp,
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_index,
  input  wire logic [pmq_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire pmq_pkg::ctrl_cmd_t             cmd,
  output pmq_pkg::dp_status_t                 status
);

  localparam int AW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int IW   = (AW > pmq_pkg::PTR_W) ? AW : pmq_pkg::PTR_W;
  localparam int QW   = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
  localparam int KW   = (QW > pmq_pkg::QNUM_W) ? QW : pmq_pkg::QNUM_W;
  localparam int PW   = pmq_pkg::PTR_W;

  logic [pmq_pkg::SLOTS_W-1:0] total_slots;
  logic [pmq_pkg::QCNT_W-1:0]  queue_count;
  logic                        div_go;
  logic                        div_busy;
  logic [pmq_pkg::SLOTS_W-1:0] seg_size;

  pmq_pkg::req_t               req_q;
  logic                        bad_q;
  logic [pmq_pkg::QNUM_W-1:0]  k;
  logic [KW-1:0]               k_ext;
  logic [QW-1:0]               qidx;
  logic [PW-1:0]               base;
  logic [MAX_QUEUES-1:0]       qvalid;

  logic [2*PW-1:0]             ptr_rd;
  logic [PW-1:0]               front;
  logic [PW-1:0]               rear;
  logic [PW-1:0]               front_next;
  logic [PW-1:0]               rear_next;
  pmq_pkg::status_t            status_next;
  logic                        enq_ok;
  logic                        deq_ok_next;
  logic [IW-1:0]               wr_idx;
  logic [IW-1:0]               rd_idx;
  logic [pmq_pkg::WORD_W-1:0]  store_rd;

  pmq_pkg::status_t            res_status;
  logic                        res_empty;
  logic                        res_full;
  logic                        deq_ok;

  // Configuration registers; any write empties every queue and reruns the divide
  always_ff @(posedge clk) begin
    if (rst) begin
      total_slots <= pmq_pkg::clamp_slots(pmq_pkg::SLOTS_W'(pmq_pkg::RESET_TOTAL_SLOTS),
                                          MAX_SLOTS);
      queue_count <= pmq_pkg::clamp_queues(pmq_pkg::QCNT_W'(pmq_pkg::RESET_QUEUE_COUNT),
                                           MAX_QUEUES);
      div_go      <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pmq_pkg::CFG_TOTAL_SLOTS: total_slots <= pmq_pkg::clamp_slots(cfg_data, MAX_SLOTS);
        pmq_pkg::CFG_QUEUE_COUNT:
          queue_count <= pmq_pkg::clamp_queues(cfg_data[pmq_pkg::QCNT_W-1:0], MAX_QUEUES);
      endcase
      div_go <= 1'b1;
    end else begin
      div_go <= 1'b0;
    end
  end

  pmq_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (total_slots),
    .divisor  (queue_count),
    .busy     (div_busy),
    .quotient (seg_size)
  );

  // Latch the accepted word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
      bad_q <= (req.queue_number == '0) || (req.queue_number > queue_count);
    end
  end

  assign k     = req_q.queue_number - 1'b1;
  assign k_ext = KW'(k);
  assign qidx  = k_ext[QW-1:0];

  // Segment base, ready by the update cycle
  always_ff @(posedge clk) begin
    base <= PW'(k * seg_size);
  end

  // Front and rear offsets of each queue, packed in one word
  pmq_ram #(
    .WIDTH (2 * PW),
    .DEPTH (MAX_QUEUES)
  ) u_ptr_ram (
    .clk   (clk),
    .wen   (cmd.update && !bad_q),
    .waddr (qidx),
    .wdata ({front_next, rear_next}),
    .ren   (1'b1),
    .raddr (qidx),
    .rdata (ptr_rd)
  );

  // A queue not touched since reset or the last configuration write reads as empty
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      qvalid <= '0;
    end else if (cmd.update && !bad_q) begin
      qvalid[qidx] <= 1'b1;
    end
  end

  assign front = qvalid[qidx] ? ptr_rd[2*PW-1:PW] : '0;
  assign rear  = qvalid[qidx] ? ptr_rd[PW-1:0] : '0;

  always_comb begin
    front_next  = front;
    rear_next   = rear;
    status_next = pmq_pkg::ST_OK;
    enq_ok      = 1'b0;
    deq_ok_next = 1'b0;
    unique case (req_q.cmd)
      pmq_pkg::CMD_ENQ: begin
        if (rear >= seg_size) begin
          status_next = pmq_pkg::ST_FULL;
        end else begin
          enq_ok    = 1'b1;
          rear_next = rear + 1'b1;
        end
      end
      pmq_pkg::CMD_DEQ: begin
        if (front >= rear) begin
          status_next = pmq_pkg::ST_EMPTY;
        end else begin
          deq_ok_next = 1'b1;
          front_next  = front + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign wr_idx = IW'(base) + IW'(rear);
  assign rd_idx = IW'(base) + IW'(front);

  pmq_ram #(
    .WIDTH (pmq_pkg::WORD_W),
    .DEPTH (MAX_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .wen   (cmd.update && !bad_q && enq_ok),
    .waddr (wr_idx[AW-1:0]),
    .wdata (req_q.value),
    .ren   (cmd.update && !bad_q && deq_ok_next),
    .raddr (rd_idx[AW-1:0]),
    .rdata (store_rd)
  );

  // Result of the update, held until hand-off
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      if (bad_q) begin
        res_status <= pmq_pkg::ST_BAD_QUEUE;
        res_empty  <= 1'b0;
        res_full   <= 1'b0;
        deq_ok     <= 1'b0;
      end else begin
        res_status <= status_next;
        res_empty  <= front_next >= rear_next;
        res_full   <= rear_next >= seg_size;
        deq_ok     <= deq_ok_next;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp.status     <= res_status;
      rsp.data_out   <= deq_ok ? store_rd : '0;
      rsp.empty_flag <= res_empty;
      rsp.full_flag  <= res_full;
    end
  end

  assign status.busy     = div_go || div_busy;
  assign status.rsp_free = !rsp_valid || !rsp_stall;

endmodule

`default_nettype wire

/* hw/rtl/pmq_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module pmq_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire logic                cfg_we,
  input  wire pmq_pkg::dp_status_t status,
  output pmq_pkg::ctrl_cmd_t       cmd
);

  typedef enum logic [1:0] {
    IDLE,
    LOOKUP,
    UPDATE,
    HANDOFF
  } state_t;

  state_t state;

  // Hold off new words while busy, dividing, or taking a register write
  assign req_stall  = (state != IDLE) || status.busy || cfg_we;
  assign cmd.load   = req_valid && !req_stall;
  assign cmd.update = state == UPDATE;
  assign cmd.emit   = (state == HANDOFF) && status.rsp_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE:    if (cmd.load) state <= LOOKUP;
        LOOKUP:  state <= UPDATE;
        UPDATE:  state <= HANDOFF;
        HANDOFF: if (status.rsp_free) state <= IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
